// ===== src/grid_neighbor_cell_indices_macros.svh =====
// Assertion macros used by the checker file of the neighbor cell block.
`ifndef GRID_NEIGHBOR_CELL_INDICES_MACROS_SVH
`define GRID_NEIGHBOR_CELL_INDICES_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define GNCI_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("gnci check failed");

// Next-cycle implication, off while reset is high.
`define GNCI_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("gnci check failed");

// Next-cycle implication that also holds across reset.
`define GNCI_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("gnci check failed");

`endif

// ===== src/gnci_pkg.sv =====
// Types, constants and register codes of the grid neighbor cell index block.
package gnci_pkg;

  localparam int MAX_CELLS_PER_AXIS_DEF = 64;
  localparam int CELL_W   = 18;
  localparam int CFG_W    = 31;
  localparam int CPA_W    = 7;
  localparam int POS_W    = 32;
  localparam int NUM_POS  = 27;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  // One world unit in Q16.16, at the width of an offset position.
  localparam logic signed [33:0] ONE_UNIT = 34'sd65536;

  localparam logic [2:0] REG_WORLD_X = 3'd0;
  localparam logic [2:0] REG_WORLD_Y = 3'd1;
  localparam logic [2:0] REG_WORLD_Z = 3'd2;
  localparam logic [2:0] REG_CELL_X  = 3'd3;
  localparam logic [2:0] REG_CELL_Y  = 3'd4;
  localparam logic [2:0] REG_CELL_Z  = 3'd5;
  localparam logic [2:0] REG_CELLS   = 3'd6;

  localparam logic [CFG_W-1:0] WORLD_RESET = 31'd4194304;
  localparam logic [CFG_W-1:0] CELL_RESET  = 31'd262144;
  localparam logic [CPA_W-1:0] CELLS_RESET = 7'd16;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } gnci_query_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_number;
    logic              last_of_run;
  } gnci_result_t;

  // Index 0 is x, 1 is y, 2 is z.
  typedef struct packed {
    logic [2:0][CFG_W-1:0] world;
    logic [2:0][CFG_W-1:0] cell_size;
    logic [CPA_W-1:0]      cells_per_axis;
  } gnci_cfg_t;

  // One classified query: which of the 27 neighbors are in range and the
  // per-axis index terms, x already times n*n and y times n.
  typedef struct packed {
    logic [NUM_POS-1:0]     mask;
    logic [2:0][CELL_W-1:0] tx;
    logic [2:0][CELL_W-1:0] ty;
    logic [2:0][CELL_W-1:0] tz;
  } gnci_entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } gnci_fstate_t;

endpackage

// ===== src/gnci_div.sv =====
// One lane of the saturating restoring divider, one quotient bit per step.
module gnci_div #(
  parameter int QW = $clog2(gnci_pkg::MAX_CELLS_PER_AXIS_DEF)
) (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       step,
  input  logic [gnci_pkg::CFG_W-1:0] num,
  input  logic [gnci_pkg::CFG_W-1:0] den,
  output logic [QW:0]                quo
);
  import gnci_pkg::*;

  localparam int DW = CFG_W + QW;

  logic [CFG_W-1:0] rem;
  logic [DW-1:0]    dsh;
  logic [DW-1:0]    rem_ext;
  logic [DW-1:0]    diff;
  logic             ge;

  assign rem_ext = DW'(rem);
  assign ge      = rem_ext >= dsh;
  assign diff    = rem_ext - dsh;

  // Top quotient bit set means the quotient is at least 2**QW: caller
  // saturates. A zero divisor sets every bit, which saturates too.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {QW{1'b0}}};
      quo <= '0;
    end else if (step) begin
      if (ge) begin
        rem <= diff[CFG_W-1:0];
      end
      dsh <= dsh >> 1;
      quo <= {quo[QW-1:0], ge};
    end
  end

endmodule

// ===== src/gnci_fifo.sv =====
// Short queue of classified queries between the front and back parts.
module gnci_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gnci_pkg::gnci_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output gnci_pkg::gnci_entry_t head,
  output logic                  empty
);
  import gnci_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  gnci_entry_t         entries [DEPTH];
  logic [AW-1:0]       wptr;
  logic [AW-1:0]       rptr;
  logic [CNTW-1:0]     count;

  assign full  = count == CNTW'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

// ===== src/gnci_front.sv =====
// Front part: takes a query, range-checks the nine offset coordinates,
// divides them into cell numbers and forms the index terms.
module gnci_front #(
  parameter int MAX_CELLS = gnci_pkg::MAX_CELLS_PER_AXIS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gnci_pkg::gnci_cfg_t   cfg,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  gnci_pkg::gnci_query_t req_data,
  output logic                  push,
  output gnci_pkg::gnci_entry_t push_data,
  input  logic                  full
);
  import gnci_pkg::*;

  localparam int QW   = $clog2(MAX_CELLS);
  localparam int NW   = $clog2(MAX_CELLS + 1);
  localparam int CW   = (NW > CPA_W) ? NW : CPA_W;
  localparam int SCW  = $clog2(QW + 2);
  localparam int PW1  = QW + NW;
  localparam int PWX  = (PW1 + NW > CELL_W) ? PW1 + NW : CELL_W;

  gnci_fstate_t           state, state_next;
  logic [SCW-1:0]         cnt;
  logic                   accept;
  logic                   step;

  logic [CW-1:0]          n_wide;
  logic [NW-1:0]          n;
  logic [QW-1:0]          nm1;

  logic [2:0][POS_W-1:0]  pos;
  logic [8:0]             in_range;
  logic [8:0][CFG_W-1:0]  num;
  logic [8:0][QW:0]       qx;
  logic [8:0][QW-1:0]     cq;
  logic [8:0]             vld;

  logic [2:0][PW1-1:0]    xn;
  logic [2:0][CELL_W-1:0] xt;
  logic [2:0][CELL_W-1:0] yt;
  logic [2:0][CELL_W-1:0] zt;
  logic [2:0][PWX-1:0]    prod_x;
  logic [2:0][PWX-1:0]    prod_y;

  // cells_per_axis: zero acts as one, large values clamp to the maximum
  always_comb begin
    if (cfg.cells_per_axis == '0) begin
      n_wide = CW'(1);
    end else if (CW'(cfg.cells_per_axis) > CW'(MAX_CELLS)) begin
      n_wide = CW'(MAX_CELLS);
    end else begin
      n_wide = CW'(cfg.cells_per_axis);
    end
  end
  assign n   = n_wide[NW-1:0];
  assign nm1 = QW'(n - 1'b1);

  assign pos = {req_data.pos_z, req_data.pos_y, req_data.pos_x};

  // Lane l handles axis l/3 at offset (l%3)-1 world units.
  for (genvar l = 0; l < 9; l++) begin : g_lane
    localparam int A = l / 3;
    localparam int D = l % 3;
    localparam logic signed [33:0] OFFS =
      (D == 0) ? -ONE_UNIT : ((D == 2) ? ONE_UNIT : 34'sd0);

    logic [33:0] c;

    assign c = {{2{pos[A][POS_W-1]}}, pos[A]} + OFFS;
    assign in_range[l] = !c[33] && (c[32:0] < 33'(cfg.world[A]));
    assign num[l] = c[CFG_W-1:0];

    gnci_div #(.QW(QW)) u_div (
      .clk   (clk),
      .start (accept),
      .step  (step),
      .num   (num[l]),
      .den   (cfg.cell_size[A]),
      .quo   (qx[l])
    );

    assign cq[l] = (qx[l][QW] || (qx[l][QW-1:0] > nm1)) ? nm1 : qx[l][QW-1:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_x[i] = PWX'(xn[i]) * PWX'(n);
      prod_y[i] = PWX'(cq[3 + i]) * PWX'(n);
    end
  end

  always_comb begin
    push_data.tx = xt;
    push_data.ty = yt;
    push_data.tz = zt;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          push_data.mask[i*9 + j*3 + k] = vld[i] & vld[3 + j] & vld[6 + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    step       = 1'b0;
    push       = 1'b0;
    req_stall  = 1'b1;
    case (state)
      F_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          accept     = 1'b1;
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        step = 1'b1;
        if (cnt == SCW'(QW)) begin
          state_next = F_MUL1;
        end
      end
      F_MUL1: begin
        state_next = F_MUL2;
      end
      F_MUL2: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        // the next query may start while this one is handed over
        if (!full) begin
          push      = 1'b1;
          req_stall = 1'b0;
          if (req_valid) begin
            accept     = 1'b1;
            state_next = F_DIV;
          end else begin
            state_next = F_IDLE;
          end
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vld <= in_range;
    end
    if (state == F_MUL1) begin
      for (int i = 0; i < 3; i++) begin
        xn[i] <= PW1'(cq[i]) * PW1'(n);
        yt[i] <= prod_y[i][CELL_W-1:0];
        zt[i] <= CELL_W'(cq[6 + i]);
      end
    end
    if (state == F_MUL2) begin
      for (int i = 0; i < 3; i++) begin
        xt[i] <= prod_x[i][CELL_W-1:0];
      end
    end
  end

endmodule

// ===== src/gnci_back.sv =====
// Back part: walks the in-range neighbors of one query and emits their indices.
module gnci_back (
  input  logic                   clk,
  input  logic                   rst,
  input  gnci_pkg::gnci_entry_t  head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output gnci_pkg::gnci_result_t rsp_data
);
  import gnci_pkg::*;

  logic [NUM_POS-1:0]     rem;
  logic [NUM_POS-1:0]     low;
  logic [2:0][CELL_W-1:0] tx;
  logic [2:0][CELL_W-1:0] ty;
  logic [2:0][CELL_W-1:0] tz;
  logic [4:0]             pos;
  logic [4:0]             r9;
  logic [1:0]             xi;
  logic [1:0]             yi;
  logic [1:0]             zi;
  logic                   slot_free;
  logic                   emit;
  logic                   last;
  logic                   done;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign emit      = (|rem) && slot_free;
  assign low       = rem & (~rem + 1'b1);
  assign last      = (rem & ~low) == '0;
  // a query with no neighbor in range is dropped as soon as it is popped
  assign done      = !(|rem) || (emit && last);
  assign pop       = done && !empty;

  always_comb begin
    pos = '0;
    for (int b = NUM_POS - 1; b >= 0; b--) begin
      if (rem[b]) begin
        pos = 5'(b);
      end
    end
  end

  // position is x*9 + y*3 + z
  always_comb begin
    if (pos >= 5'd18) begin
      xi = 2'd2;
      r9 = pos - 5'd18;
    end else if (pos >= 5'd9) begin
      xi = 2'd1;
      r9 = pos - 5'd9;
    end else begin
      xi = 2'd0;
      r9 = pos;
    end
    if (r9 >= 5'd6) begin
      yi = 2'd2;
      zi = 2'(r9 - 5'd6);
    end else if (r9 >= 5'd3) begin
      yi = 2'd1;
      zi = 2'(r9 - 5'd3);
    end else begin
      yi = 2'd0;
      zi = 2'(r9);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        rem <= head.mask;
      end else if (emit) begin
        rem <= rem & ~low;
      end
      if (slot_free) begin
        rsp_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tx <= head.tx;
      ty <= head.ty;
      tz <= head.tz;
    end
    if (emit) begin
      rsp_data.cell_number <= tx[xi] + ty[yi] + tz[zi];
      rsp_data.last_of_run <= last;
    end
  end

endmodule

// ===== src/grid_neighbor_cell_indices.sv =====
// Top level of the 3-D uniform grid neighbor cell index generator.
// Each query point (signed Q16.16 per axis) yields the linear cell index of
// every in-range point among its 27 neighbors at -1, 0, +1 world unit per
// axis, x outermost and z innermost, with the last index of a query flagged;
// a query with no neighbor in range yields nothing. The front part divides
// each query in the nine saturating divider lanes, which make one quotient
// bit per cycle of a Q+1 bit quotient, Q = clog2(MAX_CELLS_PER_AXIS) (6 at
// the default), then forms the index terms in its multiply states before the
// queue handoff. The back part emits one index per cycle into a registered
// output while it is not stalled; the front may start the next query while
// the last one is handed over. A two-entry queue between the parts lets the
// front take new queries while results wait. Registers sit at byte address
// 4*i in the order world size x/y/z, cell size x/y/z, cells per axis; write
// them only while the block is idle.
module grid_neighbor_cell_indices #(
  parameter int MAX_CELLS_PER_AXIS = gnci_pkg::MAX_CELLS_PER_AXIS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gnci_pkg::PADDR_W-1:0]   paddr,
  input  logic [gnci_pkg::PDATA_W-1:0]   pwdata,
  output logic [gnci_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  gnci_pkg::gnci_query_t          req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output gnci_pkg::gnci_result_t         rsp_data
);
  import gnci_pkg::*;

  gnci_cfg_t   cfg;
  logic [2:0]  reg_idx;
  logic        wr;
  logic        push;
  logic        full;
  logic        pop;
  logic        empty;
  gnci_entry_t push_data;
  gnci_entry_t head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.world          <= {3{WORLD_RESET}};
      cfg.cell_size      <= {3{CELL_RESET}};
      cfg.cells_per_axis <= CELLS_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_WORLD_X: cfg.world[0]       <= pwdata[CFG_W-1:0];
        REG_WORLD_Y: cfg.world[1]       <= pwdata[CFG_W-1:0];
        REG_WORLD_Z: cfg.world[2]       <= pwdata[CFG_W-1:0];
        REG_CELL_X:  cfg.cell_size[0]   <= pwdata[CFG_W-1:0];
        REG_CELL_Y:  cfg.cell_size[1]   <= pwdata[CFG_W-1:0];
        REG_CELL_Z:  cfg.cell_size[2]   <= pwdata[CFG_W-1:0];
        REG_CELLS:   cfg.cells_per_axis <= pwdata[CPA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WORLD_X: prdata = PDATA_W'(cfg.world[0]);
      REG_WORLD_Y: prdata = PDATA_W'(cfg.world[1]);
      REG_WORLD_Z: prdata = PDATA_W'(cfg.world[2]);
      REG_CELL_X:  prdata = PDATA_W'(cfg.cell_size[0]);
      REG_CELL_Y:  prdata = PDATA_W'(cfg.cell_size[1]);
      REG_CELL_Z:  prdata = PDATA_W'(cfg.cell_size[2]);
      REG_CELLS:   prdata = PDATA_W'(cfg.cells_per_axis);
      default:     prdata = '0;
    endcase
  end

  gnci_front #(.MAX_CELLS(MAX_CELLS_PER_AXIS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  gnci_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  gnci_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== src/gnci_checker.sv =====
// Port-level checks of the neighbor cell block, bound to its top level.
`include "grid_neighbor_cell_indices_macros.svh"

module gnci_checker (
  input logic                           clk,
  input logic                           rst,
  input logic [gnci_pkg::PDATA_W-1:0]   prdata,
  input logic                           pready,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input gnci_pkg::gnci_result_t         rsp_data
);
  import gnci_pkg::*;

  `GNCI_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  `GNCI_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp_data))
  `GNCI_ASSERT_NEXT_ALWAYS(a_rsp_reset, clk, rst, !rsp_valid)
  `GNCI_ASSERT_IMPLIES(a_pready, clk, rst, 1'b1, pready)
  `GNCI_ASSERT_IMPLIES(a_prdata_msb, clk, rst, 1'b1, !prdata[PDATA_W-1])

endmodule

bind grid_neighbor_cell_indices gnci_checker u_gnci_checker (.*);
